// ===== rtl/cfs_pkg.sv =====
// shared types, constants and the control program of the can frame serializer
// no dependencies; every rtl file refers to it by scoped names
`default_nettype none

package cfs_pkg;

    localparam int MAX_PAYLOAD_BYTES = 8;
    localparam int CHUNK_W           = 8;
    localparam int VALID_W           = 4;
    localparam int FILL_W            = (CHUNK_W > 1) ? $clog2(CHUNK_W) : 1;

    localparam int BASE_W = 11;
    localparam int EXT_W  = 18;
    localparam int DLC_W  = 4;
    localparam int DATA_W = 64;
    localparam int CRC_W  = 15;
    localparam int NB_W   = 4;
    localparam int LEN_W  = 7;
    localparam int STEP_W = 5;
    localparam int RUN_W  = 3;

    localparam logic [CRC_W-1:0] CRC_POLY  = 15'h4599;
    localparam logic [RUN_W-1:0] STUFF_RUN = 3'd5;
    localparam int               TAIL_BITS = 10;

    // step addresses used as jump targets
    localparam logic [STEP_W-1:0] ST_STD_HDR = 5'd3;
    localparam logic [STEP_W-1:0] ST_EXT_HDR = 5'd8;
    localparam logic [STEP_W-1:0] ST_DATA_CK = 5'd15;
    localparam logic [STEP_W-1:0] ST_CRC     = 5'd17;

    typedef enum logic [1:0] {
        OP_EMIT = 2'd0,
        OP_JUMP = 2'd1,
        OP_END  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_ONE  = 3'd1,
        SRC_BASE = 3'd2,
        SRC_EXT  = 3'd3,
        SRC_RTR  = 3'd4,
        SRC_DLC  = 3'd5,
        SRC_DATA = 3'd6,
        SRC_CRC  = 3'd7
    } t_src;

    typedef enum logic [1:0] {
        COND_ALWAYS = 2'd0,
        COND_EXT    = 2'd1,
        COND_NODATA = 2'd2
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_src              src;
        logic [LEN_W-1:0]  len;
        logic              len_data;
        logic              stuff;
        logic              fin;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic emit;
        t_src src;
        logic stuff;
        logic last;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic             stall;
        logic             ide;
        logic             nodata;
        logic [LEN_W-1:0] data_len;
    } t_stat;

    function automatic t_uword emit_w(input t_src src, input int len, input logic len_data,
                                      input logic stuff, input logic fin);
        t_uword w;
        w.op       = OP_EMIT;
        w.src      = src;
        w.len      = LEN_W'(len);
        w.len_data = len_data;
        w.stuff    = stuff;
        w.fin      = fin;
        w.cond     = COND_ALWAYS;
        w.target   = '0;
        return w;
    endfunction

    function automatic t_uword jump_w(input t_cond cond, input logic [STEP_W-1:0] target);
        t_uword w;
        w.op       = OP_JUMP;
        w.src      = SRC_ZERO;
        w.len      = '0;
        w.len_data = 1'b0;
        w.stuff    = 1'b0;
        w.fin      = 1'b0;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    // control program: one word per step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w        = jump_w(COND_ALWAYS, '0);
        w.op     = OP_END;
        case (step)
            5'd0:  w = emit_w(SRC_ZERO, 1, 1'b0, 1'b1, 1'b0);       // sof
            5'd1:  w = emit_w(SRC_BASE, BASE_W, 1'b0, 1'b1, 1'b0);
            5'd2:  w = jump_w(COND_EXT, ST_EXT_HDR);
            5'd3:  w = emit_w(SRC_RTR, 1, 1'b0, 1'b1, 1'b0);
            5'd4:  w = emit_w(SRC_ZERO, 1, 1'b0, 1'b1, 1'b0);       // ide
            5'd5:  w = emit_w(SRC_ZERO, 1, 1'b0, 1'b1, 1'b0);       // r0
            5'd6:  w = emit_w(SRC_DLC, DLC_W, 1'b0, 1'b1, 1'b0);
            5'd7:  w = jump_w(COND_ALWAYS, ST_DATA_CK);
            5'd8:  w = emit_w(SRC_ONE, 1, 1'b0, 1'b1, 1'b0);        // srr
            5'd9:  w = emit_w(SRC_ONE, 1, 1'b0, 1'b1, 1'b0);        // ide
            5'd10: w = emit_w(SRC_EXT, EXT_W, 1'b0, 1'b1, 1'b0);
            5'd11: w = emit_w(SRC_RTR, 1, 1'b0, 1'b1, 1'b0);
            5'd12: w = emit_w(SRC_ZERO, 1, 1'b0, 1'b1, 1'b0);       // r1
            5'd13: w = emit_w(SRC_ZERO, 1, 1'b0, 1'b1, 1'b0);       // r0
            5'd14: w = emit_w(SRC_DLC, DLC_W, 1'b0, 1'b1, 1'b0);
            5'd15: w = jump_w(COND_NODATA, ST_CRC);
            5'd16: w = emit_w(SRC_DATA, 0, 1'b1, 1'b1, 1'b0);
            5'd17: w = emit_w(SRC_CRC, CRC_W, 1'b0, 1'b1, 1'b0);
            5'd18: w = emit_w(SRC_ONE, TAIL_BITS, 1'b0, 1'b0, 1'b1); // delimiters and eof
            default: begin
                w.op = OP_END;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfs_sequencer.sv =====
// step counter, bit counter and jump logic over the control program
// depends on cfs_pkg (program table, control and status structs)
`default_nettype none

module cfs_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire cfs_pkg::t_stat i_stat,
    output cfs_pkg::t_ctrl      o_ctrl
);

    logic [cfs_pkg::STEP_W-1:0] r_step, n_step;
    logic [cfs_pkg::LEN_W-1:0]  r_cnt, n_cnt;
    logic                       r_active, n_active;

    cfs_pkg::t_uword            uw;
    logic [cfs_pkg::LEN_W-1:0]  len;
    logic                       step_done;
    logic                       cond_true;
    logic                       run;

    always_comb begin
        uw        = cfs_pkg::ucode(r_step);
        len       = uw.len_data ? i_stat.data_len : uw.len;
        step_done = (cfs_pkg::LEN_W'(r_cnt + 1'b1) == len);
        run       = r_active && !i_stat.stall;
        case (uw.cond)
            cfs_pkg::COND_EXT:    cond_true = i_stat.ide;
            cfs_pkg::COND_NODATA: cond_true = i_stat.nodata;
            default:              cond_true = 1'b1;
        endcase

        o_ctrl.emit  = run && (uw.op == cfs_pkg::OP_EMIT);
        o_ctrl.src   = uw.src;
        o_ctrl.stuff = uw.stuff;
        o_ctrl.last  = uw.fin && step_done;
    end

    always_comb begin
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_active = r_active;
        if (i_load) begin
            n_step   = '0;
            n_cnt    = '0;
            n_active = 1'b1;
        end else if (run) begin
            case (uw.op)
                cfs_pkg::OP_EMIT: begin
                    if (step_done) begin
                        n_step = cfs_pkg::STEP_W'(r_step + 1'b1);
                        n_cnt  = '0;
                        if (uw.fin) begin
                            n_active = 1'b0;
                        end
                    end else begin
                        n_cnt = cfs_pkg::LEN_W'(r_cnt + 1'b1);
                    end
                end
                cfs_pkg::OP_JUMP: begin
                    n_step = cond_true ? uw.target : cfs_pkg::STEP_W'(r_step + 1'b1);
                end
                default: begin
                    n_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_cnt    <= '0;
            r_active <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfs_datapath.sv =====
// field shift registers, crc-15 and bit stuffing of the can frame serializer
// depends on cfs_pkg (widths, source codes, control and status structs)
`default_nettype none

module cfs_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic [cfs_pkg::BASE_W-1:0]   i_base_id,
    input  wire logic [cfs_pkg::EXT_W-1:0]    i_extension_id,
    input  wire logic                         i_extended_frame,
    input  wire logic                         i_remote_request,
    input  wire logic [cfs_pkg::DLC_W-1:0]    i_length_code,
    input  wire logic [cfs_pkg::DATA_W-1:0]   i_payload,
    input  wire cfs_pkg::t_ctrl               i_ctrl,
    output cfs_pkg::t_stat                    o_stat,
    output logic                              o_bit,
    output logic                              o_bit_valid,
    output logic                              o_last
);

    logic [cfs_pkg::BASE_W-1:0] r_base, n_base;
    logic [cfs_pkg::EXT_W-1:0]  r_ext, n_ext;
    logic [cfs_pkg::DLC_W-1:0]  r_dlc, n_dlc;
    logic [cfs_pkg::DATA_W-1:0] r_data, n_data;
    logic [cfs_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic [cfs_pkg::NB_W-1:0]   r_nbytes, n_nbytes;
    logic                       r_ide, n_ide;
    logic                       r_rtr, n_rtr;

    logic [cfs_pkg::RUN_W-1:0]  r_run, n_run;
    logic                       r_prev, n_prev;
    logic                       r_pend, n_pend;

    logic                       raw;
    logic                       feed;

    always_comb begin
        case (i_ctrl.src)
            cfs_pkg::SRC_ONE:  raw = 1'b1;
            cfs_pkg::SRC_BASE: raw = r_base[cfs_pkg::BASE_W-1];
            cfs_pkg::SRC_EXT:  raw = r_ext[cfs_pkg::EXT_W-1];
            cfs_pkg::SRC_RTR:  raw = r_rtr;
            cfs_pkg::SRC_DLC:  raw = r_dlc[cfs_pkg::DLC_W-1];
            cfs_pkg::SRC_DATA: raw = r_data[cfs_pkg::DATA_W-1];
            cfs_pkg::SRC_CRC:  raw = r_crc[cfs_pkg::CRC_W-1];
            default:           raw = 1'b0;
        endcase
        feed = raw ^ r_crc[cfs_pkg::CRC_W-1];

        o_bit       = r_pend ? ~r_prev : raw;
        o_bit_valid = r_pend || i_ctrl.emit;
        o_last      = i_ctrl.emit && i_ctrl.last;

        o_stat.stall    = r_pend;
        o_stat.ide      = r_ide;
        o_stat.nodata   = (r_nbytes == '0);
        o_stat.data_len = cfs_pkg::LEN_W'({r_nbytes, 3'b000});
    end

    // field registers: each source is consumed once, msb first
    always_comb begin
        n_base   = r_base;
        n_ext    = r_ext;
        n_dlc    = r_dlc;
        n_data   = r_data;
        n_crc    = r_crc;
        n_nbytes = r_nbytes;
        n_ide    = r_ide;
        n_rtr    = r_rtr;
        if (i_load) begin
            n_base = i_base_id;
            n_ext  = i_extension_id;
            n_dlc  = i_length_code;
            n_data = i_payload;
            n_crc  = '0;
            n_ide  = i_extended_frame;
            n_rtr  = i_remote_request;
            if (i_remote_request) begin
                n_nbytes = '0;
            end else if (i_length_code > cfs_pkg::DLC_W'(cfs_pkg::MAX_PAYLOAD_BYTES)) begin
                n_nbytes = cfs_pkg::NB_W'(cfs_pkg::MAX_PAYLOAD_BYTES);
            end else begin
                n_nbytes = cfs_pkg::NB_W'(i_length_code);
            end
        end else if (i_ctrl.emit) begin
            case (i_ctrl.src)
                cfs_pkg::SRC_BASE: n_base = {r_base[cfs_pkg::BASE_W-2:0], 1'b0};
                cfs_pkg::SRC_EXT:  n_ext  = {r_ext[cfs_pkg::EXT_W-2:0], 1'b0};
                cfs_pkg::SRC_DLC:  n_dlc  = {r_dlc[cfs_pkg::DLC_W-2:0], 1'b0};
                cfs_pkg::SRC_DATA: n_data = {r_data[cfs_pkg::DATA_W-2:0], 1'b0};
                default: begin
                    n_base = r_base;
                end
            endcase
            if (i_ctrl.src == cfs_pkg::SRC_CRC) begin
                n_crc = {r_crc[cfs_pkg::CRC_W-2:0], 1'b0};
            end else if (i_ctrl.stuff) begin
                n_crc = {r_crc[cfs_pkg::CRC_W-2:0], 1'b0} ^ (feed ? cfs_pkg::CRC_POLY : '0);
            end
        end
    end

    // run tracking; the inserted bit starts the next run
    always_comb begin
        n_run  = r_run;
        n_prev = r_prev;
        n_pend = r_pend;
        if (i_load) begin
            n_run  = '0;
            n_prev = 1'b0;
            n_pend = 1'b0;
        end else if (r_pend) begin
            n_prev = ~r_prev;
            n_run  = cfs_pkg::RUN_W'(1);
            n_pend = 1'b0;
        end else if (i_ctrl.emit && i_ctrl.stuff) begin
            if ((r_run == '0) || (raw != r_prev)) begin
                n_prev = raw;
                n_run  = cfs_pkg::RUN_W'(1);
            end else begin
                n_run = cfs_pkg::RUN_W'(r_run + 1'b1);
            end
            n_pend = (n_run == cfs_pkg::STUFF_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_ext    <= n_ext;
        r_dlc    <= n_dlc;
        r_data   <= n_data;
        r_crc    <= n_crc;
        r_nbytes <= n_nbytes;
        r_ide    <= n_ide;
        r_rtr    <= n_rtr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_prev <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_prev <= n_prev;
            r_pend <= n_pend;
        end
    end

    // a pending stuff bit must freeze the program
    a_stall_blocks_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_ctrl.emit)
        else $error("program emitted a bit while a stuff bit was pending");

    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run == cfs_pkg::STUFF_RUN) |-> r_pend)
        else $error("run of five without a pending stuff bit");

endmodule

`default_nettype wire

// ===== rtl/cfs_chunker.sv =====
// packs the serial line bits into chunks, first bit in the top position
// depends on cfs_pkg (chunk and count widths)
`default_nettype none

module cfs_chunker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_bit,
    input  wire logic                          i_bit_valid,
    input  wire logic                          i_last,
    output logic                               o_done,
    output logic                               o_strobe,
    output logic [cfs_pkg::CHUNK_W-1:0]        o_line_bits,
    output logic [cfs_pkg::VALID_W-1:0]        o_valid_bits,
    output logic                               o_last_chunk
);

    logic [cfs_pkg::CHUNK_W-1:0] r_chunk, n_chunk;
    logic [cfs_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic                        r_strobe, n_strobe;
    logic [cfs_pkg::CHUNK_W-1:0] r_out, n_out;
    logic [cfs_pkg::VALID_W-1:0] r_cnt, n_cnt;
    logic                        r_olast, n_olast;

    logic [cfs_pkg::CHUNK_W-1:0] put;
    logic [cfs_pkg::FILL_W-1:0]  idx;
    logic                        flush;

    always_comb begin
        idx      = cfs_pkg::FILL_W'(cfs_pkg::CHUNK_W - 1) - r_fill;
        put      = r_chunk;
        put[idx] = i_bit;
        flush    = i_bit_valid
                   && ((r_fill == cfs_pkg::FILL_W'(cfs_pkg::CHUNK_W - 1)) || i_last);

        n_chunk  = r_chunk;
        n_fill   = r_fill;
        n_strobe = 1'b0;
        n_out    = r_out;
        n_cnt    = r_cnt;
        n_olast  = r_olast;
        if (flush) begin
            n_chunk  = '0;
            n_fill   = '0;
            n_strobe = 1'b1;
            n_out    = put;
            n_cnt    = cfs_pkg::VALID_W'(r_fill) + 1'b1;
            n_olast  = i_last;
        end else if (i_bit_valid) begin
            n_chunk = put;
            n_fill  = cfs_pkg::FILL_W'(r_fill + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk  <= '0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_chunk  <= n_chunk;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_cnt   <= n_cnt;
        r_olast <= n_olast;
    end

    assign o_done       = flush && i_last;
    assign o_strobe     = r_strobe;
    assign o_line_bits  = r_out;
    assign o_valid_bits = r_cnt;
    assign o_last_chunk = r_olast;

endmodule

`default_nettype wire

// ===== rtl/can_frame_serializer_with_stuffing.sv =====
// top level of the can frame serializer: request capture, busy flag and wiring
// depends on cfs_pkg, cfs_sequencer, cfs_datapath and cfs_chunker
//
// usage
//   a frame request is taken at a rising edge with start high and busy low;
//   the request fields are captured then and need not be held afterwards.
//   the frame leaves as a series of chunks of up to eight line bits, first
//   transmitted bit in bit 7, each shown for one cycle with o_strobe high;
//   o_valid_bits gives the valid leading bits and o_last_chunk marks the end.
//   the receiver has no way to hold results off and must take every strobe.
// timing
//   the control program produces one line bit per cycle, except while it executes
//   a program jump (three for a standard frame, two for an extended one).
//   the first chunk is strobed from the chunker's output registers once its
//   eighth line bit has been packed.
//   busy falls in the cycle of the last strobe; the next request may be taken
//   at the edge that ends it.
// reset
//   synchronous and active low; it idles the program, drops busy and clears
//   any partly filled chunk.
`default_nettype none

module can_frame_serializer_with_stuffing (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [cfs_pkg::BASE_W-1:0]    i_base_id,
    input  wire logic [cfs_pkg::EXT_W-1:0]     i_extension_id,
    input  wire logic                          i_extended_frame,
    input  wire logic                          i_remote_request,
    input  wire logic [cfs_pkg::DLC_W-1:0]     i_length_code,
    input  wire logic [cfs_pkg::DATA_W-1:0]    i_payload,
    output logic                               o_strobe,
    output logic [cfs_pkg::CHUNK_W-1:0]        o_line_bits,
    output logic [cfs_pkg::VALID_W-1:0]        o_valid_bits,
    output logic                               o_last_chunk
);

    logic           r_busy, n_busy;
    logic           load;
    logic           done;
    logic           line_bit;
    logic           line_bit_valid;
    logic           line_last;
    cfs_pkg::t_ctrl ctrl;
    cfs_pkg::t_stat stat;

    assign load = start && !r_busy;
    assign busy = r_busy;

    always_comb begin
        n_busy = r_busy;
        if (load) begin
            n_busy = 1'b1;
        end else if (done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    cfs_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    cfs_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (load),
        .i_base_id        (i_base_id),
        .i_extension_id   (i_extension_id),
        .i_extended_frame (i_extended_frame),
        .i_remote_request (i_remote_request),
        .i_length_code    (i_length_code),
        .i_payload        (i_payload),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .o_bit            (line_bit),
        .o_bit_valid      (line_bit_valid),
        .o_last           (line_last)
    );

    cfs_chunker u_chunk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit        (line_bit),
        .i_bit_valid  (line_bit_valid),
        .i_last       (line_last),
        .o_done       (done),
        .o_strobe     (o_strobe),
        .o_line_bits  (o_line_bits),
        .o_valid_bits (o_valid_bits),
        .o_last_chunk (o_last_chunk)
    );

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy did not rise");

    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_chunk) |-> !busy)
        else $error("busy still high on the final chunk transfer");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_valid_bits != '0)
                      && (o_valid_bits <= cfs_pkg::VALID_W'(cfs_pkg::CHUNK_W))))
        else $error("chunk transfer with a bad valid bit count");

    a_no_bits_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !line_bit_valid)
        else $error("line bit produced while no frame is in progress");

endmodule

`default_nettype wire
